>>> src/dnd_pkg.sv
`default_nettype none

package dnd_pkg;

  localparam int PACKET_DEPTH = 512;
  localparam int NAME_CAP     = 64;

  localparam int ADDR_W = $clog2(PACKET_DEPTH);
  localparam int NAME_W = $clog2(NAME_CAP);
  localparam int POS_W  = 9;
  localparam int SIZE_W = 10;
  localparam int BYTE_W = 8;
  localparam int CONS_W = 10;
  localparam int JUMP_W = 4;
  localparam int TGT_W  = 14;
  localparam int WALK_W = 13;

  localparam logic [BYTE_W-1:0] PTR_MARK      = 8'hC0;
  localparam logic [BYTE_W-1:0] PTR_HIGH_MASK = 8'h3F;
  localparam logic [BYTE_W-1:0] DOT_CHAR      = 8'h2E;
  localparam logic [JUMP_W-1:0] MAX_JUMPS     = 4'd10;
  localparam logic [TGT_W-1:0]  HEADER_BYTES  = 14'd12;
  localparam logic [CONS_W-1:0] CONS_MAX      = 10'h3FF;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LOOP   = 3'd1,
    ST_TRUNC  = 3'd2,
    ST_HEADER = 3'd3,
    ST_BEYOND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_CUR_NEXT,
    RD_COPY
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LEN,
    S_LEN,
    S_PTR_LO,
    S_COPY,
    S_FINISH,
    S_EMIT_RD,
    S_EMIT_WR,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic    start;
    logic    store_wr;
    rd_sel_e rd_sel;
    logic    eval_len;
    logic    jump_inc;
    logic    label_start;
    logic    ptr_take;
    logic    copy_step;
    logic    copy_end;
    logic    finish;
    logic    emit_char;
    logic    emit_final;
    logic    set_err;
    status_e err_code;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic jump_limit;
    logic is_ptr;
    logic ptr_trunc;
    logic tgt_header;
    logic tgt_beyond;
    logic copy_more;
    logic emit_done;
    logic out_free;
  } flags_t;

endpackage

`default_nettype wire

>>> src/dnd_ctrl.sv
`default_nettype none

module dnd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            kind_i,
  output logic            in_stall_o,
  input  dnd_pkg::flags_t flags_i,
  output dnd_pkg::cmd_t   cmd_o
);

  dnd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dnd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dnd_pkg::S_IDLE: begin
        if (in_valid_i && (kind_i == dnd_pkg::KIND_DECODE)) begin
          state_d = dnd_pkg::S_RD_LEN;
        end
      end
      dnd_pkg::S_RD_LEN: begin
        state_d = dnd_pkg::S_LEN;
      end
      dnd_pkg::S_LEN: begin
        if (flags_i.len_zero) begin
          state_d = dnd_pkg::S_FINISH;
        end else if (flags_i.jump_limit) begin
          state_d = dnd_pkg::S_FINAL;
        end else if (flags_i.is_ptr) begin
          state_d = flags_i.ptr_trunc ? dnd_pkg::S_FINAL : dnd_pkg::S_PTR_LO;
        end else begin
          state_d = dnd_pkg::S_COPY;
        end
      end
      dnd_pkg::S_PTR_LO: begin
        if (flags_i.tgt_header || flags_i.tgt_beyond) begin
          state_d = dnd_pkg::S_FINAL;
        end else begin
          state_d = dnd_pkg::S_RD_LEN;
        end
      end
      dnd_pkg::S_COPY: begin
        if (!flags_i.copy_more) begin
          state_d = dnd_pkg::S_RD_LEN;
        end
      end
      dnd_pkg::S_FINISH: begin
        state_d = dnd_pkg::S_EMIT_RD;
      end
      dnd_pkg::S_EMIT_RD: begin
        state_d = flags_i.emit_done ? dnd_pkg::S_FINAL : dnd_pkg::S_EMIT_WR;
      end
      dnd_pkg::S_EMIT_WR: begin
        if (flags_i.out_free) begin
          state_d = dnd_pkg::S_EMIT_RD;
        end
      end
      dnd_pkg::S_FINAL: begin
        if (flags_i.out_free) begin
          state_d = dnd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dnd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = dnd_pkg::RD_CUR;
    cmd_o.err_code = dnd_pkg::ST_OK;
    in_stall_o     = 1'b1;
    case (state_q)
      dnd_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.start    = in_valid_i && (kind_i == dnd_pkg::KIND_DECODE);
        cmd_o.store_wr = in_valid_i && (kind_i == dnd_pkg::KIND_LOAD);
      end
      dnd_pkg::S_RD_LEN: begin
        cmd_o.rd_sel = dnd_pkg::RD_CUR;
      end
      dnd_pkg::S_LEN: begin
        cmd_o.eval_len = 1'b1;
        cmd_o.rd_sel   = dnd_pkg::RD_CUR_NEXT;
        if (!flags_i.len_zero) begin
          if (flags_i.jump_limit) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = dnd_pkg::ST_LOOP;
          end else if (flags_i.is_ptr) begin
            cmd_o.jump_inc = 1'b1;
            if (flags_i.ptr_trunc) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = dnd_pkg::ST_TRUNC;
            end
          end else begin
            cmd_o.label_start = 1'b1;
          end
        end
      end
      dnd_pkg::S_PTR_LO: begin
        if (flags_i.tgt_header) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = dnd_pkg::ST_HEADER;
        end else if (flags_i.tgt_beyond) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = dnd_pkg::ST_BEYOND;
        end else begin
          cmd_o.ptr_take = 1'b1;
        end
      end
      dnd_pkg::S_COPY: begin
        cmd_o.rd_sel    = dnd_pkg::RD_COPY;
        cmd_o.copy_step = flags_i.copy_more;
        cmd_o.copy_end  = !flags_i.copy_more;
      end
      dnd_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      dnd_pkg::S_EMIT_RD: begin
        cmd_o.rd_sel = dnd_pkg::RD_CUR;
      end
      dnd_pkg::S_EMIT_WR: begin
        cmd_o.emit_char = flags_i.out_free;
      end
      dnd_pkg::S_FINAL: begin
        cmd_o.emit_final = flags_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/dnd_dpath.sv
`default_nettype none

module dnd_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dnd_pkg::cmd_t                cmd_i,
  output dnd_pkg::flags_t              flags_o,
  input  logic [dnd_pkg::POS_W-1:0]    position_i,
  input  logic [dnd_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [dnd_pkg::SIZE_W-1:0]   packet_size_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dnd_pkg::BYTE_W-1:0]   name_char_o,
  output logic                         last_o,
  output logic [2:0]                   status_o,
  output logic [dnd_pkg::CONS_W-1:0]   consumed_o
);

  logic [dnd_pkg::BYTE_W-1:0] pkt_mem [dnd_pkg::PACKET_DEPTH];
  logic [dnd_pkg::BYTE_W-1:0] name_mem [dnd_pkg::NAME_CAP];

  logic [dnd_pkg::BYTE_W-1:0] pkt_rd_q;
  logic                       rd_ok_q;
  logic [dnd_pkg::BYTE_W-1:0] name_rd_q;

  logic [dnd_pkg::WALK_W-1:0] cur_q;
  logic [dnd_pkg::WALK_W-1:0] resume_q;
  logic [dnd_pkg::POS_W-1:0]  pos_q;
  logic [dnd_pkg::SIZE_W-1:0] size_q;
  logic [dnd_pkg::BYTE_W-1:0] len_q;
  logic [dnd_pkg::BYTE_W-1:0] cnt_q;
  logic [dnd_pkg::BYTE_W-1:0] last_char_q;
  logic [dnd_pkg::CONS_W-1:0] cons_q;

  dnd_pkg::status_e           status_q;
  logic                       jumped_q;
  logic                       after_label_q;
  logic [dnd_pkg::JUMP_W-1:0] jumps_q;
  logic [dnd_pkg::NAME_W-1:0] nlen_q;
  logic [dnd_pkg::NAME_W-1:0] k_q;

  logic                       out_valid_q;
  logic [dnd_pkg::BYTE_W-1:0] out_char_q;
  logic                       out_last_q;
  dnd_pkg::status_e           out_status_q;
  logic [dnd_pkg::CONS_W-1:0] out_cons_q;

  logic [dnd_pkg::WALK_W-1:0] rd_addr;
  logic [dnd_pkg::WALK_W-1:0] size_ext;
  logic                       rd_ok_d;
  logic                       wr_en;
  logic [dnd_pkg::BYTE_W-1:0] byte_val;
  logic [dnd_pkg::BYTE_W-1:0] ptr_hi;
  logic [dnd_pkg::TGT_W-1:0]  target;
  logic                       not_full;
  logic                       dot_wr;
  logic                       name_wr;
  logic [dnd_pkg::BYTE_W-1:0] name_wdata;
  logic                       trim;
  logic [dnd_pkg::WALK_W-1:0] span;
  logic [dnd_pkg::CONS_W-1:0] cons_d;
  logic                       out_free;
  logic                       out_load;

  assign size_ext = dnd_pkg::WALK_W'(size_q);

  always_comb begin
    case (cmd_i.rd_sel)
      dnd_pkg::RD_CUR:      rd_addr = cur_q;
      dnd_pkg::RD_CUR_NEXT: rd_addr = cur_q + dnd_pkg::WALK_W'(1);
      dnd_pkg::RD_COPY:     rd_addr = cur_q + dnd_pkg::WALK_W'(cnt_q) + dnd_pkg::WALK_W'(1);
      default:              rd_addr = cur_q;
    endcase
  end

  // bytes past the packet or past the store read as zero
  assign rd_ok_d = (rd_addr < size_ext)
                && (rd_addr < dnd_pkg::WALK_W'(dnd_pkg::PACKET_DEPTH));
  assign wr_en   = cmd_i.store_wr
                && (dnd_pkg::WALK_W'(position_i) < dnd_pkg::WALK_W'(dnd_pkg::PACKET_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pkt_mem[dnd_pkg::ADDR_W'(position_i)] <= data_byte_i;
    end
    pkt_rd_q <= pkt_mem[dnd_pkg::ADDR_W'(rd_addr)];
    rd_ok_q  <= rd_ok_d;
  end

  assign byte_val = rd_ok_q ? pkt_rd_q : '0;
  assign ptr_hi   = len_q & dnd_pkg::PTR_HIGH_MASK;
  assign target   = {ptr_hi[dnd_pkg::TGT_W-dnd_pkg::BYTE_W-1:0], byte_val};
  assign not_full = (nlen_q != dnd_pkg::NAME_W'(dnd_pkg::NAME_CAP - 1));

  // separator goes in when a label is followed by a nonzero byte
  assign dot_wr     = cmd_i.eval_len && after_label_q && (byte_val != '0) && not_full;
  assign name_wr    = dot_wr || cmd_i.copy_step;
  assign name_wdata = dot_wr ? dnd_pkg::DOT_CHAR : byte_val;
  assign trim       = (nlen_q != '0) && (last_char_q == dnd_pkg::DOT_CHAR);

  always_ff @(posedge clk_i) begin
    if (name_wr) begin
      name_mem[nlen_q] <= name_wdata;
    end
    name_rd_q <= name_mem[k_q];
  end

  always_comb begin
    if (jumped_q) begin
      span = resume_q - dnd_pkg::WALK_W'(pos_q);
    end else begin
      span = cur_q - dnd_pkg::WALK_W'(pos_q) + dnd_pkg::WALK_W'(1);
    end
    if (span > dnd_pkg::WALK_W'(dnd_pkg::CONS_MAX)) begin
      cons_d = dnd_pkg::CONS_MAX;
    end else begin
      cons_d = span[dnd_pkg::CONS_W-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.emit_char || cmd_i.emit_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q      <= dnd_pkg::ST_OK;
      jumped_q      <= 1'b0;
      after_label_q <= 1'b0;
      jumps_q       <= '0;
      nlen_q        <= '0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        status_q      <= dnd_pkg::ST_OK;
        jumped_q      <= 1'b0;
        after_label_q <= 1'b0;
        jumps_q       <= '0;
        nlen_q        <= '0;
      end
      if (cmd_i.set_err) begin
        status_q <= cmd_i.err_code;
      end
      if (cmd_i.jump_inc) begin
        jumps_q <= jumps_q + dnd_pkg::JUMP_W'(1);
      end
      if (cmd_i.ptr_take) begin
        jumped_q      <= 1'b1;
        after_label_q <= 1'b0;
      end
      if (cmd_i.copy_end) begin
        after_label_q <= 1'b1;
      end
      if (name_wr) begin
        nlen_q <= nlen_q + dnd_pkg::NAME_W'(1);
      end
      if (cmd_i.finish) begin
        k_q <= '0;
        if (trim) begin
          nlen_q <= nlen_q - dnd_pkg::NAME_W'(1);
        end
      end
      if (cmd_i.emit_char) begin
        k_q <= k_q + dnd_pkg::NAME_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q  <= dnd_pkg::WALK_W'(position_i);
      pos_q  <= position_i;
      size_q <= packet_size_i;
    end
    if (cmd_i.eval_len) begin
      len_q <= byte_val;
    end
    if (cmd_i.label_start) begin
      cur_q <= cur_q + dnd_pkg::WALK_W'(1);
      cnt_q <= '0;
    end
    if (cmd_i.ptr_take) begin
      if (!jumped_q) begin
        resume_q <= cur_q + dnd_pkg::WALK_W'(2);
      end
      cur_q <= dnd_pkg::WALK_W'(target);
    end
    if (cmd_i.copy_step) begin
      cnt_q <= cnt_q + dnd_pkg::BYTE_W'(1);
    end
    if (cmd_i.copy_end) begin
      cur_q <= cur_q + dnd_pkg::WALK_W'(len_q);
    end
    if (name_wr) begin
      last_char_q <= name_wdata;
    end
    if (cmd_i.finish) begin
      cons_q <= cons_d;
    end
    if (cmd_i.emit_char) begin
      out_char_q   <= name_rd_q;
      out_last_q   <= 1'b0;
      out_status_q <= dnd_pkg::ST_OK;
      out_cons_q   <= '0;
    end
    if (cmd_i.emit_final) begin
      out_char_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= status_q;
      out_cons_q   <= (status_q == dnd_pkg::ST_OK) ? cons_q : '0;
    end
  end

  assign flags_o.len_zero   = (byte_val == '0);
  assign flags_o.jump_limit = (jumps_q >= dnd_pkg::MAX_JUMPS);
  assign flags_o.is_ptr     = ((byte_val & dnd_pkg::PTR_MARK) == dnd_pkg::PTR_MARK);
  assign flags_o.ptr_trunc  = ((cur_q + dnd_pkg::WALK_W'(1)) >= size_ext);
  assign flags_o.tgt_header = (target < dnd_pkg::HEADER_BYTES);
  assign flags_o.tgt_beyond = (target >= dnd_pkg::TGT_W'(size_q));
  assign flags_o.copy_more  = (cnt_q < len_q)
                           && ((cur_q + dnd_pkg::WALK_W'(cnt_q)) < size_ext)
                           && not_full;
  assign flags_o.emit_done  = (k_q == nlen_q);
  assign flags_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign name_char_o = out_char_q;
  assign last_o      = out_last_q;
  assign status_o    = out_status_q;
  assign consumed_o  = out_cons_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a pending transfer");

  a_jumps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jumps_q <= dnd_pkg::MAX_JUMPS)
    else $error("jump count past limit");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_char |-> (k_q < nlen_q))
    else $error("character emitted past name length");

  a_err_no_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q && (out_status_q != dnd_pkg::ST_OK))
      |-> (out_cons_q == '0))
    else $error("error result carries consumed count");
`endif

endmodule

`default_nettype wire

>>> src/dns_name_decompressor.sv
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | kind_i, position_i, data_byte_i, packet_size_i
// out     | out_valid_o| out_stall_i | name_char_o, last_o, status_o, consumed_o
//
// a load is written to the packet store without stalling the input; a decode stalls
// the input while it reads each length byte, copies label bytes, follows pointers,
// trims a trailing dot, then emits each name character and the final result, paced
// by the one registered read port of the packet store
// reset clears control only; the packet store holds garbage until loaded
// out_stall_i holds a decode in its emit states; the final result waits in the
// output register while the next item is taken
`default_nettype none

module dns_name_decompressor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [dnd_pkg::POS_W-1:0]  position_i,
  input  logic [dnd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic [dnd_pkg::SIZE_W-1:0] packet_size_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dnd_pkg::BYTE_W-1:0] name_char_o,
  output logic                       last_o,
  output logic [2:0]                 status_o,
  output logic [dnd_pkg::CONS_W-1:0] consumed_o
);

  dnd_pkg::cmd_t   cmd;
  dnd_pkg::flags_t flags;

  dnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  dnd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .position_i    (position_i),
    .data_byte_i   (data_byte_i),
    .packet_size_i (packet_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .name_char_o   (name_char_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .consumed_o    (consumed_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/dns_name_decompressor_tb.sv
`timescale 1ns / 1ps

module dns_name_decompressor_tb;

  localparam int unsigned RANDOM_ITEMS   = 130;
  localparam int unsigned FILL_BYTES     = 200;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned TAIL_CYCLES    = 50;

  typedef struct packed {
    logic [dnd_pkg::BYTE_W-1:0] name_char;
    logic                       last;
    dnd_pkg::status_e           status;
    logic [dnd_pkg::CONS_W-1:0] consumed;
  } name_result_t;

  class name_scoreboard;
    logic [dnd_pkg::BYTE_W-1:0] store_img [dnd_pkg::PACKET_DEPTH];
    name_result_t               name_results_q [$];
    int unsigned                fail_count = 0;

    function logic [dnd_pkg::BYTE_W-1:0] packet_byte(int unsigned addr, int unsigned size);
      if (addr >= size || addr >= dnd_pkg::PACKET_DEPTH) return '0;
      return store_img[addr];
    endfunction

    function void push_result(logic [dnd_pkg::BYTE_W-1:0] ch, logic lst,
                              dnd_pkg::status_e st, logic [dnd_pkg::CONS_W-1:0] cons);
      name_result_t r;
      r.name_char = ch;
      r.last      = lst;
      r.status    = st;
      r.consumed  = cons;
      name_results_q.push_back(r);
    endfunction

    // walk labels and pointers from start, queue the characters and the final transfer
    function void walk_name(int unsigned start, int unsigned size);
      logic [dnd_pkg::BYTE_W-1:0] chars [$];
      int unsigned cur, len, jumps, resume, cons, tgt;
      bit jumped;
      dnd_pkg::status_e verdict;
      cur = start;
      jumps = 0;
      resume = 0;
      jumped = 1'b0;
      verdict = dnd_pkg::ST_OK;
      while (verdict == dnd_pkg::ST_OK && cur < size && packet_byte(cur, size) != 0) begin
        len = packet_byte(cur, size);
        if (jumps >= dnd_pkg::MAX_JUMPS) begin
          verdict = dnd_pkg::ST_LOOP;
        end else if ((len & dnd_pkg::PTR_MARK) == dnd_pkg::PTR_MARK) begin
          jumps++;
          if (cur + 1 >= size) begin
            verdict = dnd_pkg::ST_TRUNC;
          end else begin
            tgt = ((len & dnd_pkg::PTR_HIGH_MASK) << 8) | packet_byte(cur + 1, size);
            if (tgt < dnd_pkg::HEADER_BYTES) verdict = dnd_pkg::ST_HEADER;
            else if (tgt >= size) verdict = dnd_pkg::ST_BEYOND;
            else begin
              if (!jumped) resume = cur + 2;
              cur = tgt;
              jumped = 1'b1;
            end
          end
        end else begin
          cur++;
          for (int unsigned i = 0; i < len && cur + i < size; i++) begin
            if (chars.size() < dnd_pkg::NAME_CAP - 1) chars.push_back(packet_byte(cur + i, size));
          end
          cur += len;
          if (packet_byte(cur, size) != 0 && chars.size() < dnd_pkg::NAME_CAP - 1)
            chars.push_back(dnd_pkg::DOT_CHAR);
        end
      end
      if (verdict != dnd_pkg::ST_OK) begin
        push_result('0, 1'b1, verdict, '0);
        return;
      end
      if (chars.size() > 0 && chars[$] == dnd_pkg::DOT_CHAR) void'(chars.pop_back());
      cons = jumped ? resume - start : cur - start + 1;
      if (cons > dnd_pkg::CONS_MAX) cons = dnd_pkg::CONS_MAX;
      foreach (chars[k]) push_result(chars[k], 1'b0, dnd_pkg::ST_OK, '0);
      push_result('0, 1'b1, dnd_pkg::ST_OK, cons[dnd_pkg::CONS_W-1:0]);
    endfunction

    function void note_transfer(logic kind, logic [dnd_pkg::POS_W-1:0] pos,
                                logic [dnd_pkg::BYTE_W-1:0] dbyte,
                                logic [dnd_pkg::SIZE_W-1:0] size);
      if (kind == dnd_pkg::KIND_LOAD) begin
        if (pos < dnd_pkg::PACKET_DEPTH) store_img[pos] = dbyte;
      end else begin
        walk_name(pos, size);
      end
    endfunction

    function int outstanding();
      return name_results_q.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      fail_count++;
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
    endtask

    task check_result(logic [dnd_pkg::BYTE_W-1:0] ch, logic lst, logic [2:0] st,
                      logic [dnd_pkg::CONS_W-1:0] cons);
      name_result_t want;
      if (name_results_q.size() == 0) begin
        report_mismatch("unexpected result", ch, 0);
        return;
      end
      want = name_results_q.pop_front();
      if (ch !== want.name_char) report_mismatch("name_char", ch, want.name_char);
      if (lst !== want.last) report_mismatch("last", lst, want.last);
      if (st !== want.status) report_mismatch("status", st, want.status);
      if (cons !== want.consumed) report_mismatch("consumed", cons, want.consumed);
    endtask
  endclass

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic                        kind_i        = dnd_pkg::KIND_LOAD;
  logic [dnd_pkg::POS_W-1:0]   position_i    = '0;
  logic [dnd_pkg::BYTE_W-1:0]  data_byte_i   = '0;
  logic [dnd_pkg::SIZE_W-1:0]  packet_size_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [dnd_pkg::BYTE_W-1:0]  name_char_o;
  logic                        last_o;
  logic [2:0]                  status_o;
  logic [dnd_pkg::CONS_W-1:0]  consumed_o;

  name_scoreboard              sb;
  logic [dnd_pkg::BYTE_W-1:0]  pkt_img [dnd_pkg::PACKET_DEPTH];
  int unsigned                 name_starts [$];
  int unsigned                 items_sent  = 0;
  int unsigned                 idle_cycles = 0;
  bit                          calm_in     = 1'b0;
  bit                          calm_out    = 1'b0;
  bit                          hold_req    = 1'b0;

  dns_name_decompressor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .data_byte_i   (data_byte_i),
    .packet_size_i (packet_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .name_char_o   (name_char_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .consumed_o    (consumed_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void place_byte(int unsigned a, logic [dnd_pkg::BYTE_W-1:0] v);
    if (a < dnd_pkg::PACKET_DEPTH) pkt_img[a] = v;
  endfunction

  function automatic void place_pointer(int unsigned a, logic [dnd_pkg::TGT_W-1:0] tgt);
    place_byte(a, dnd_pkg::PTR_MARK | {2'b00, tgt[13:8]});
    place_byte(a + 1, tgt[7:0]);
  endfunction

  // length byte then label bytes, mostly lower-case letters
  function automatic void place_label(ref int unsigned p, input int unsigned len,
                                      input bit plain);
    place_byte(p, len[dnd_pkg::BYTE_W-1:0]);
    p++;
    repeat (len) begin
      if (plain || $urandom_range(0, 4) != 0)
        place_byte(p, dnd_pkg::BYTE_W'(8'h61 + $urandom_range(0, 25)));
      else place_byte(p, dnd_pkg::BYTE_W'($urandom_range(0, 255)));
      p++;
    end
  endfunction

  task automatic send_item(logic k, int unsigned pos, int unsigned dbyte, int unsigned psize);
    int unsigned gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    position_i    <= pos[dnd_pkg::POS_W-1:0];
    data_byte_i   <= dbyte[dnd_pkg::BYTE_W-1:0];
    packet_size_i <= psize[dnd_pkg::SIZE_W-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic compose_directed();
    int unsigned p;
    for (int a = 0; a < dnd_pkg::PACKET_DEPTH; a++)
      pkt_img[a] = dnd_pkg::BYTE_W'($urandom_range(0, 255));
    p = 12;
    place_label(p, 1, 1'b1);
    place_label(p, 2, 1'b1);
    place_byte(p, 8'h00);
    place_pointer(18, 12);
    p = 20;
    place_label(p, 3, 1'b1);
    place_pointer(p, 12);
    place_pointer(26, 5);
    place_byte(28, 8'hFF);
    place_byte(29, 8'hFF);
    place_pointer(30, 30);
    // ten hops, then a label
    for (int h = 0; h < 10; h++) place_pointer(32 + 2 * h, 34 + 2 * h);
    p = 52;
    place_label(p, 1, 1'b1);
    place_byte(p, 8'h00);
    p = 55;
    place_label(p, 63, 1'b1);
    place_label(p, 5, 1'b1);
    place_byte(p, 8'h00);
    p = 126;
    place_label(p, 62, 1'b1);
    place_label(p, 1, 1'b1);
    place_byte(p, 8'h00);
    // reserved prefix running past the packet end
    place_byte(192, 8'h80);
  endtask

  task automatic compose_packet(int unsigned size);
    int unsigned p, pick;
    logic [dnd_pkg::TGT_W-1:0] tgt;
    name_starts.delete();
    p = 12;
    while (p < size) begin
      name_starts.push_back(p);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        repeat ($urandom_range(1, 4)) begin
          place_label(p, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63)
                                                     : $urandom_range(1, 12), 1'b0);
        end
        if (name_starts.size() > 1 && $urandom_range(0, 2) == 0) begin
          place_pointer(p, dnd_pkg::TGT_W'(
            name_starts[$urandom_range(0, name_starts.size() - 2)]));
          p += 2;
        end else begin
          place_byte(p, 8'h00);
          p++;
        end
      end else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0: tgt = dnd_pkg::TGT_W'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
          1:       tgt = dnd_pkg::TGT_W'(p);
          2:       tgt = dnd_pkg::TGT_W'($urandom_range(0, 11));
          default: tgt = dnd_pkg::TGT_W'($urandom_range(0, 16383));
        endcase
        place_pointer(p, tgt);
        p += 2;
      end else if (pick < 88) begin
        // pointer chain around the jump limit
        repeat ($urandom_range(8, 11)) begin
          place_pointer(p, dnd_pkg::TGT_W'(p + 2));
          p += 2;
        end
        place_label(p, $urandom_range(1, 5), 1'b0);
        place_byte(p, 8'h00);
        p++;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          place_byte(p, dnd_pkg::BYTE_W'($urandom_range(0, 255)));
          p++;
        end
      end
    end
  endtask

  task automatic run_scenario();
    int unsigned size, pick, start, dsize;
    size = $urandom_range(16, 96);
    compose_packet(size);
    for (int a = 12; a < size; a++)
      send_item(dnd_pkg::KIND_LOAD, a, pkt_img[a], $urandom_range(0, dnd_pkg::PACKET_DEPTH));
    repeat ($urandom_range(6, 12)) begin
      pick  = $urandom_range(0, 9);
      start = name_starts[$urandom_range(0, name_starts.size() - 1)];
      dsize = size;
      case (pick)
        6: start = $urandom_range(0, size - 1);
        7: begin
          start = $urandom_range(0, dnd_pkg::PACKET_DEPTH - 1);
          dsize = $urandom_range(0, FILL_BYTES);
        end
        8:       dsize = FILL_BYTES;
        9:       dsize = $urandom_range(0, size);
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0)
        send_item(dnd_pkg::KIND_LOAD, $urandom_range(0, dnd_pkg::PACKET_DEPTH - 1),
                  $urandom_range(0, 255), $urandom_range(0, dnd_pkg::PACKET_DEPTH));
      send_item(dnd_pkg::KIND_DECODE, start, $urandom_range(0, 255), dsize);
    end
  endtask

  // result side
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pick_gap(calm_out);
      if (hold_req) begin
        hold_req = 1'b0;
        gap += HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        sb.note_transfer(kind_i, position_i, data_byte_i, packet_size_i);
        moved = 1'b1;
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        sb.check_result(name_char_o, last_o, status_o, consumed_o);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dns_name_decompressor regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned dir_pos [20];
    int unsigned dir_size [20];
    int unsigned base, scen;
    sb = new();
    dir_pos  = '{12, 18, 20, 26, 28, 28, 30, 32, 34, 55,
                 126, 20, 150, 12, 192, 199, 0, 17, 24, 52};
    dir_size = '{200, 200, 200, 200, 100, 29, 200, 200, 200, 200,
                 200, 22, 100, 0, 200, 200, 200, 200, 200, 53};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    compose_directed();
    for (int a = 0; a < FILL_BYTES; a++)
      send_item(dnd_pkg::KIND_LOAD, a, pkt_img[a], $urandom_range(0, dnd_pkg::PACKET_DEPTH));
    for (int d = 0; d < 20; d++)
      send_item(dnd_pkg::KIND_DECODE, dir_pos[d], $urandom_range(0, 255), dir_size[d]);

    base = items_sent;
    scen = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      if (scen == 0 || scen == 1) hold_req = 1'b1;
      run_scenario();
      scen++;
    end
    in_valid_i <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0) $display("dns_name_decompressor regression: pass");
    else $display("dns_name_decompressor regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
src/dnd_pkg.sv
src/dnd_ctrl.sv
src/dnd_dpath.sv
src/dns_name_decompressor.sv
tb/sv/dns_name_decompressor_tb.sv
